// File: rtl/edd_pkg.sv
// Shared types, constants and the error attenuation table of the error diffusion dither.
package edd_pkg;

    localparam int FW_W  = 11;
    localparam int FH_W  = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IW = 1;
    localparam int PIX_W = 8;
    localparam int CORR_W = 9;
    localparam int MAG_W = 7;

    localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1;

    typedef logic signed [CORR_W-1:0] corr_t;

    typedef struct packed {
        logic last_col;
        logic last_row;
        logic has_left;
        logic row_nz;
    } pos_flags_t;

    typedef logic [MAG_W-1:0] atten_lut_t [128];

    // round(|d| * 0.605), half up, for every error magnitude 0..127
    function automatic atten_lut_t build_atten_lut();
        atten_lut_t lut;
        for (int i = 0; i < 128; i++)
        begin
            lut[i] = MAG_W'((i * 605 + 500) / 1000);
        end
        return lut;
    endfunction

    localparam atten_lut_t ATTEN_LUT = build_atten_lut();

endpackage

// File: rtl/edd_linebuf.sv
// Line buffer memory for next-row corrections, one write and one registered read per cycle.
module edd_linebuf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic signed [edd_pkg::CORR_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic signed [edd_pkg::CORR_W-1:0] rdata
);
    import edd_pkg::*;

    corr_t mem [DEPTH];
    corr_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/edd_position.sv
// Frame geometry registers and the raster position of the next pixel to be accepted.
module edd_position #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [edd_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [edd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         acc,
    output logic [AW-1:0]                x,
    output edd_pkg::pos_flags_t          flags
);
    import edd_pkg::*;

    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [AW-1:0]   col_reg;
    logic [AW-1:0]   col_next;
    logic [FH_W-1:0] row_reg;
    logic [FH_W-1:0] row_next;
    logic [16:0]     w_sat;
    logic [AW-1:0]   last_x;
    logic [FH_W-1:0] last_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero acts as one column, anything past the buffer acts as its full width
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_sat = 17'd1;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_sat = 17'(MAX_WIDTH);
        end
        else
        begin
            w_sat = 17'(width_reg);
        end
    end

    assign last_x = AW'(w_sat - 17'd1);
    assign last_y = (height_reg == '0) ? '0 : height_reg - 16'd1;

    assign flags.last_col = (col_reg >= last_x);
    assign flags.last_row = (row_reg >= last_y);
    assign x              = flags.last_col ? last_x : col_reg;
    assign flags.has_left = (x != '0);
    assign flags.row_nz   = (row_reg != '0);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc)
        begin
            if (flags.last_col)
            begin
                col_next = '0;
                row_next = flags.last_row ? '0 : row_reg + 16'd1;
            end
            else
            begin
                col_next = x + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: rtl/edd_diffuse.sv
// Quantize stage: corrected pixel, threshold, error shares, buffer writes and result register.
module edd_diffuse #(
    parameter int AW = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_acc,
    input  logic [edd_pkg::PIX_W-1:0]         gray,
    input  logic [AW-1:0]                     x,
    input  edd_pkg::pos_flags_t               flags,
    input  logic signed [edd_pkg::CORR_W-1:0] rdata,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic signed [edd_pkg::CORR_W-1:0] wr_data,
    output logic                              in_stall,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [edd_pkg::PIX_W-1:0]         bw_level,
    output logic                              row_end,
    output logic                              frame_end
);
    import edd_pkg::*;

    // pixel stage
    logic              pix_valid_reg;
    logic              pix_valid_next;
    logic [PIX_W-1:0]  pix_gray_reg;
    logic [AW-1:0]     pix_x_reg;
    pos_flags_t        pix_flags_reg;
    logic              fwd_hit_reg;
    corr_t             fwd_data_reg;
    logic              fwd_hit_next;
    corr_t             fwd_data_next;

    // carried corrections
    corr_t rc_reg,  rc_next;
    corr_t pbl_reg, pbl_next;
    corr_t pb_reg,  pb_next;

    // deferred write of the last column
    logic          pw_valid_reg;
    logic [AW-1:0] pw_addr_reg;
    corr_t         pw_data_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] bw_reg;
    logic             row_end_reg;
    logic             frame_end_reg;

    logic             pix_adv;
    corr_t            below;
    logic signed [10:0] sum;
    logic [PIX_W-1:0] v;
    logic             white;
    logic [MAG_W-1:0] ad;
    logic [MAG_W-1:0] mag;
    logic [9:0]       p7, p3, p5;
    corr_t            m7, m3, m5, m1;
    corr_t            sh7, sh3, sh5, sh1;
    corr_t            here;
    corr_t            left_wr;
    logic             dfr_en;

    assign in_stall = pix_valid_reg && out_valid_reg && out_stall;
    assign pix_adv  = pix_valid_reg && !(out_valid_reg && out_stall);

    assign below = !pix_flags_reg.row_nz ? corr_t'(0) :
                   (fwd_hit_reg ? fwd_data_reg : rdata);
    assign sum   = $signed({3'b000, pix_gray_reg})
                 + $signed({{2{rc_reg[CORR_W-1]}}, rc_reg})
                 + $signed({{2{below[CORR_W-1]}}, below});

    always_comb
    begin
        if (sum[10])
        begin
            v = '0;
        end
        else if (sum[9:8] != 2'b00)
        begin
            v = 8'd255;
        end
        else
        begin
            v = sum[7:0];
        end
    end

    // white pixels leave a negative error of magnitude 255 - v
    assign white = v[7];
    assign ad    = white ? ~v[6:0] : v[6:0];
    assign mag   = ATTEN_LUT[ad];

    assign p7 = 10'(mag) * 10'd7;
    assign p3 = 10'(mag) * 10'd3;
    assign p5 = 10'(mag) * 10'd5;
    assign m7 = corr_t'({3'b000, p7[9:4]});
    assign m3 = corr_t'({3'b000, p3[9:4]});
    assign m5 = corr_t'({3'b000, p5[9:4]});
    assign m1 = corr_t'({6'b000000, mag[6:4]});

    assign sh7 = pix_flags_reg.last_col ? corr_t'(0) : (white ? -m7 : m7);
    assign sh3 = (pix_flags_reg.last_row || !pix_flags_reg.has_left) ? corr_t'(0) :
                 (white ? -m3 : m3);
    assign sh5 = pix_flags_reg.last_row ? corr_t'(0) : (white ? -m5 : m5);
    assign sh1 = (pix_flags_reg.last_row || pix_flags_reg.last_col) ? corr_t'(0) :
                 (white ? -m1 : m1);

    assign here    = pb_reg + sh5;
    assign left_wr = pbl_reg + sh3;
    assign dfr_en  = pix_adv && pix_flags_reg.last_col;

    // the pixel after a row end is column zero and writes nothing, so the port is free
    always_comb
    begin
        if (pw_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pw_addr_reg;
            wr_data = pw_data_reg;
        end
        else
        begin
            wr_en   = pix_adv && pix_flags_reg.has_left;
            wr_addr = pix_x_reg - AW'(1);
            wr_data = left_wr;
        end
    end

    // forward writes the read of this beat misses; the deferred value is newest
    always_comb
    begin
        fwd_hit_next  = 1'b0;
        fwd_data_next = wr_data;
        if (dfr_en && (pix_x_reg == x))
        begin
            fwd_hit_next  = 1'b1;
            fwd_data_next = here;
        end
        else if (wr_en && (wr_addr == x))
        begin
            fwd_hit_next  = 1'b1;
        end
    end

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (in_acc)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_adv)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rc_next  = rc_reg;
        pbl_next = pbl_reg;
        pb_next  = pb_reg;
        if (pix_adv)
        begin
            if (pix_flags_reg.last_col)
            begin
                rc_next  = '0;
                pbl_next = '0;
                pb_next  = '0;
            end
            else
            begin
                rc_next  = sh7;
                pbl_next = here;
                pb_next  = sh1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pix_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            pw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rc_reg        <= '0;
            pbl_reg       <= '0;
            pb_reg        <= '0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            pw_valid_reg  <= dfr_en;
            out_valid_reg <= out_valid_next;
            rc_reg        <= rc_next;
            pbl_reg       <= pbl_next;
            pb_reg        <= pb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix_gray_reg  <= gray;
            pix_x_reg     <= x;
            pix_flags_reg <= flags;
            fwd_hit_reg   <= fwd_hit_next;
            fwd_data_reg  <= fwd_data_next;
        end
        if (dfr_en)
        begin
            pw_addr_reg <= pix_x_reg;
            pw_data_reg <= here;
        end
        if (pix_adv)
        begin
            bw_reg        <= white ? 8'd255 : 8'd0;
            row_end_reg   <= pix_flags_reg.last_col;
            frame_end_reg <= pix_flags_reg.last_col && pix_flags_reg.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign bw_level  = bw_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: rtl/error_diffusion_dither.sv
// Error diffusion dither top level: gray pixels in raster order to black or white pixels.
// Takes one pixel per clock unless the output stalls; pixel and result are each registered;
// the rate is set by the registered loop that carries the right-hand correction from one
// pixel to the next, and by the line buffer, one memory of MAX_WIDTH corrections with one
// write and one registered read per cycle (the row-end correction is written in the cycle
// after the row ends, with forwarding covering reads of it). The buffer is not cleared at
// reset: the first row ignores it, and later rows read what earlier rows wrote. Write
// frame_width and frame_height only while no pixel is in flight.
module error_diffusion_dither #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [edd_pkg::CFG_IW-1:0] cfg_index,
    input  logic [edd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [edd_pkg::PIX_W-1:0]  gray_level,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [edd_pkg::PIX_W-1:0]  bw_level,
    output logic                       row_end,
    output logic                       frame_end
);
    import edd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic          in_acc;
    logic [AW-1:0] x;
    pos_flags_t    flags;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    corr_t         wr_data;
    corr_t         rdata;

    assign in_acc = in_valid && !in_stall;

    edd_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (in_acc),
        .x         (x),
        .flags     (flags)
    );

    edd_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_linebuf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (in_acc),
        .raddr (x),
        .rdata (rdata)
    );

    edd_diffuse #(
        .AW (AW)
    ) u_diffuse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_acc    (in_acc),
        .gray      (gray_level),
        .x         (x),
        .flags     (flags),
        .rdata     (rdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bw_level  (bw_level),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

endmodule
